// ----- design/hlf_pkg.sv -----
// ----------------------------------------------------------------------------
// hlf_pkg
// shared types, constants and frame layout for the led frame encoder
// ----------------------------------------------------------------------------
`default_nettype none

package hlf_pkg;

  localparam int FRAME_LEN   = 12;
  localparam int QUEUE_DEPTH = 2;

  // color source select
  localparam logic FUNC_RGB = 1'b0;
  localparam logic FUNC_HSV = 1'b1;

  // hue geometry, 1/64 degree units
  localparam logic [11:0] HUE_SECTOR   = 12'd3840;
  localparam logic [3:0]  SECTOR_COUNT = 4'd6;
  localparam int          HUE_STEPS    = 8;

  // 979200 = 255 * 3840 = 256 * 3825
  localparam logic [19:0] HUE_SCALE   = 20'd979200;
  localparam logic [19:0] SCALE_LOW   = 20'd3825;
  // floor(2^32 / 3825), estimate is exact or one low
  localparam logic [20:0] SCALE_RECIP = 21'd1122867;
  // x / 255 == (x * 32897) >> 23 for x up to 255 * 255
  localparam logic [15:0] RECIP_255   = 16'd32897;
  localparam logic [7:0]  FULL_SCALE  = 8'd255;

  // hue sectors
  localparam logic [2:0] SEC_RED_YEL  = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN  = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN  = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU  = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG  = 3'd4;
  localparam logic [2:0] SEC_MAG_RED  = 3'd5;

  // frame layout
  localparam logic [3:0] IDX_HEADER = 4'd4;
  localparam logic [3:0] IDX_BLUE   = 4'd5;
  localparam logic [3:0] IDX_GREEN  = 4'd6;
  localparam logic [3:0] IDX_RED    = 4'd7;
  localparam logic [3:0] IDX_LAST   = 4'(FRAME_LEN - 1);

  localparam logic [7:0] START_BYTE  = 8'h00;
  localparam logic [7:0] HEADER_MARK = 8'hE0;
  localparam logic [7:0] END_BYTE    = 8'h11;

  typedef struct packed {
    logic [4:0] level;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  function automatic logic [7:0] frame_byte_of(logic [3:0] idx, color_t c);
    logic [7:0] b;
    case (idx)
      IDX_HEADER: b = HEADER_MARK | {3'b000, c.level};
      IDX_BLUE:   b = c.blue;
      IDX_GREEN:  b = c.green;
      IDX_RED:    b = c.red;
      default:    b = (idx < IDX_HEADER) ? START_BYTE : END_BYTE;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- design/hlf_color_front.sv -----
// ----------------------------------------------------------------------------
// hlf_color_front
// five-stage color pipeline: picks rgb or converts hsv, pushes into the queue
// ----------------------------------------------------------------------------
`default_nettype none

module hlf_color_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                func,
  input  wire logic [7:0]          red_in,
  input  wire logic [7:0]          green_in,
  input  wire logic [7:0]          blue_in,
  input  wire logic [14:0]         hue,
  input  wire logic [7:0]          saturation,
  input  wire logic [7:0]          brightness_value,
  input  wire logic [4:0]          global_level,
  output logic                     push_valid,
  input  wire logic                push_ready,
  output hlf_pkg::color_t          push_data
);

  logic [4:0] vld;
  logic       adv;

  assign adv        = !vld[4] || push_ready;
  assign in_ready   = adv;
  assign push_valid = vld[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  // stage 1: sector and remainder
  logic [3:0]  hq;
  logic [14:0] hue_base;
  logic [14:0] rem_full;
  logic [2:0]  sec_c;

  always_comb begin
    hq = '0;
    for (int i = 1; i <= hlf_pkg::HUE_STEPS; i++) begin
      if (hue >= 15'(i * 3840)) begin
        hq = hq + 4'd1;
      end
    end
    hue_base = {11'd0, hq} * 15'(hlf_pkg::HUE_SECTOR);
    rem_full = hue - hue_base;
    sec_c    = (hq >= hlf_pkg::SECTOR_COUNT) ? 3'(hq - hlf_pkg::SECTOR_COUNT) : hq[2:0];
  end

  logic            func1;
  hlf_pkg::color_t dir1;
  logic [7:0]      v1;
  logic [7:0]      s1;
  logic [11:0]     rem1;
  logic [2:0]      sec1;

  // stage 2: products
  logic            func2;
  hlf_pkg::color_t dir2;
  logic [7:0]      v2;
  logic [2:0]      sec2;
  logic [15:0]     pprod2;
  logic [19:0]     sr2;
  logic [19:0]     st2;

  // stage 3: p and the q, t numerators
  logic            func3;
  hlf_pkg::color_t dir3;
  logic [7:0]      v3;
  logic [2:0]      sec3;
  logic [7:0]      p3;
  logic [27:0]     nq3;
  logic [27:0]     nt3;

  // stage 4: quotient estimates
  logic            func4;
  hlf_pkg::color_t dir4;
  logic [7:0]      v4;
  logic [2:0]      sec4;
  logic [7:0]      p4;
  logic [19:0]     yq4;
  logic [19:0]     yt4;
  logic [7:0]      eq4;
  logic [7:0]      et4;

  logic [31:0] pmul;
  logic [19:0] aq;
  logic [19:0] at;
  logic [19:0] yq;
  logic [19:0] yt;
  logic [40:0] mq;
  logic [40:0] mt;

  assign pmul = 32'(pprod2) * 32'(hlf_pkg::RECIP_255);
  assign aq   = hlf_pkg::HUE_SCALE - sr2;
  assign at   = hlf_pkg::HUE_SCALE - st2;
  assign yq   = nq3[27:8];
  assign yt   = nt3[27:8];
  assign mq   = 41'(yq) * 41'(hlf_pkg::SCALE_RECIP);
  assign mt   = 41'(yt) * 41'(hlf_pkg::SCALE_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      func1       <= func;
      dir1.level  <= global_level;
      dir1.red    <= red_in;
      dir1.green  <= green_in;
      dir1.blue   <= blue_in;
      v1          <= brightness_value;
      s1          <= saturation;
      rem1        <= rem_full[11:0];
      sec1        <= sec_c;

      func2  <= func1;
      dir2   <= dir1;
      v2     <= v1;
      sec2   <= sec1;
      pprod2 <= {8'd0, v1} * {8'd0, hlf_pkg::FULL_SCALE - s1};
      sr2    <= 20'(s1) * 20'(rem1);
      st2    <= 20'(s1) * 20'(hlf_pkg::HUE_SECTOR - rem1);

      func3 <= func2;
      dir3  <= dir2;
      v3    <= v2;
      sec3  <= sec2;
      p3    <= pmul[30:23];
      nq3   <= 28'(v2) * 28'(aq);
      nt3   <= 28'(v2) * 28'(at);

      func4 <= func3;
      dir4  <= dir3;
      v4    <= v3;
      sec4  <= sec3;
      p4    <= p3;
      yq4   <= yq;
      yt4   <= yt;
      eq4   <= mq[39:32];
      et4   <= mt[39:32];
    end
  end

  // stage 5: correct estimates, route channels
  logic [19:0]     rq;
  logic [19:0]     rt;
  logic [7:0]      q5;
  logic [7:0]      t5;
  hlf_pkg::color_t col_c;

  always_comb begin
    rq = yq4 - 20'(eq4) * hlf_pkg::SCALE_LOW;
    rt = yt4 - 20'(et4) * hlf_pkg::SCALE_LOW;
    q5 = eq4 + 8'(rq >= hlf_pkg::SCALE_LOW);
    t5 = et4 + 8'(rt >= hlf_pkg::SCALE_LOW);
    col_c.level = dir4.level;
    case (sec4)
      hlf_pkg::SEC_RED_YEL: begin
        col_c.red = v4; col_c.green = t5; col_c.blue = p4;
      end
      hlf_pkg::SEC_YEL_GRN: begin
        col_c.red = q5; col_c.green = v4; col_c.blue = p4;
      end
      hlf_pkg::SEC_GRN_CYN: begin
        col_c.red = p4; col_c.green = v4; col_c.blue = t5;
      end
      hlf_pkg::SEC_CYN_BLU: begin
        col_c.red = p4; col_c.green = q5; col_c.blue = v4;
      end
      hlf_pkg::SEC_BLU_MAG: begin
        col_c.red = t5; col_c.green = p4; col_c.blue = v4;
      end
      hlf_pkg::SEC_MAG_RED: begin
        col_c.red = v4; col_c.green = p4; col_c.blue = q5;
      end
      default: begin
        col_c.red = '0; col_c.green = '0; col_c.blue = '0;
      end
    endcase
    if (func4 == hlf_pkg::FUNC_RGB) begin
      col_c = dir4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      push_data <= col_c;
    end
  end

endmodule

`default_nettype wire

// ----- design/hlf_queue.sv -----
// ----------------------------------------------------------------------------
// hlf_queue
// small register fifo between the color pipeline and the frame sender
// ----------------------------------------------------------------------------
`default_nettype none

module hlf_queue #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  // depth must be a power of two, at least two; the block does not check it
  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             push;
  logic             pop;

  assign push_ready = count != (PW+1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- design/hlf_frame_tx.sv -----
// ----------------------------------------------------------------------------
// hlf_frame_tx
// serializes one color entry into the twelve-byte frame, output registered
// ----------------------------------------------------------------------------
`default_nettype none

module hlf_frame_tx (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire hlf_pkg::color_t pop_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           frame_byte,
  output logic [3:0]           byte_index,
  output logic                 last_byte
);

  logic            cur_valid;
  hlf_pkg::color_t cur;
  logic [3:0]      idx;
  logic            out_adv;
  logic            emit;
  logic            done;

  assign out_adv   = !out_valid || out_ready;
  assign emit      = out_adv && cur_valid;
  assign done      = emit && (idx == hlf_pkg::IDX_LAST);
  assign pop_ready = !cur_valid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_adv) begin
        out_valid <= cur_valid;
      end
      if (emit) begin
        idx <= done ? 4'd0 : idx + 4'd1;
      end
      if (pop_ready) begin
        cur_valid <= pop_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      cur <= pop_data;
    end
    if (emit) begin
      frame_byte <= hlf_pkg::frame_byte_of(idx, cur);
      byte_index <= idx;
      last_byte  <= idx == hlf_pkg::IDX_LAST;
    end
  end

endmodule

`default_nettype wire

// ----- design/hsv_to_led_frame.sv -----
// ----------------------------------------------------------------------------
// hsv_to_led_frame
// led color frame encoder: rgb or hsv color in, twelve-byte frame out
// ----------------------------------------------------------------------------
// first byte passes the five pipeline stages, the queue, the sender's entry
// register and the output register; the sender emits one byte per cycle while
// out_ready is high, setting the input rate; pipeline and queue run ahead as bytes drain
// reset clears all valid flags and counters, payload registers are not reset
// no clearing pass, input is ready again in the first cycle after reset
`default_nettype none

module hsv_to_led_frame #(
  parameter int QUEUE_DEPTH = hlf_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [7:0]  red_in,
  input  wire logic [7:0]  green_in,
  input  wire logic [7:0]  blue_in,
  input  wire logic [14:0] hue,
  input  wire logic [7:0]  saturation,
  input  wire logic [7:0]  brightness_value,
  input  wire logic [4:0]  global_level,
  // frame byte channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       frame_byte,
  output logic [3:0]       byte_index,
  output logic             last_byte
);

  localparam int CW = $bits(hlf_pkg::color_t);

  // front to queue
  logic            fq_valid;
  logic            fq_ready;
  hlf_pkg::color_t fq_data;

  // queue to sender
  logic            qs_valid;
  logic            qs_ready;
  logic [CW-1:0]   qs_bits;
  hlf_pkg::color_t qs_data;

  assign qs_data = hlf_pkg::color_t'(qs_bits);

  // color selection and hsv conversion, one transaction per cycle while the queue accepts
  hlf_color_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .red_in           (red_in),
    .green_in         (green_in),
    .blue_in          (blue_in),
    .hue              (hue),
    .saturation       (saturation),
    .brightness_value (brightness_value),
    .global_level     (global_level),
    .push_valid       (fq_valid),
    .push_ready       (fq_ready),
    .push_data        (fq_data)
  );

  // decouples the pipeline from the byte sender
  hlf_queue #(
    .WIDTH (CW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qs_valid),
    .pop_ready  (qs_ready),
    .pop_data   (qs_bits)
  );

  // frame layout and byte serialization
  hlf_frame_tx u_tx (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (qs_valid),
    .pop_ready  (qs_ready),
    .pop_data   (qs_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .last_byte  (last_byte)
  );

endmodule

`default_nettype wire
